// File: rtl/tcrd_pkg.sv
package tcrd_pkg;

	// screen store geometry
	localparam int MAX_COLUMNS = 128;
	localparam int MAX_ROWS = 64;
	localparam int COL_W = $clog2(MAX_COLUMNS);
	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int ADDR_W = COL_W + ROW_W;
	localparam int MEM_DEPTH = MAX_COLUMNS * MAX_ROWS;

	// field widths
	localparam int KIND_W = 3;
	localparam int COORD_W = 12;
	localparam int SIZE_W = 12;
	localparam int CHAR_W = 8;
	localparam int COLOR_W = 8;
	localparam int PAT_W = 3 * CHAR_W;
	localparam int CELL_W = CHAR_W + COLOR_W;
	localparam int SW_W = 8;
	localparam int SH_W = 7;

	// coordinate math room: a signed coordinate plus an unsigned size
	localparam int EXT_W = COORD_W + 2;

	// stream and register port widths
	localparam int S_TDATA_W = 88;
	localparam int M_TDATA_W = 16;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// command kinds
	localparam logic [KIND_W-1:0] KIND_WRITE = 3'd0;
	localparam logic [KIND_W-1:0] KIND_FILL = 3'd1;
	localparam logic [KIND_W-1:0] KIND_OUTLINE = 3'd2;
	localparam logic [KIND_W-1:0] KIND_PATTERN = 3'd3;
	localparam logic [KIND_W-1:0] KIND_READ = 3'd4;

	// register index, taken from the word address bit
	localparam logic REG_WIDTH = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;
	localparam logic [SW_W-1:0] WIDTH_RESET = 8'd80;
	localparam logic [SH_W-1:0] HEIGHT_RESET = 7'd25;

	// blank cell
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [2:0] DEFAULT_FG = 3'd7;
	localparam logic [2:0] DEFAULT_BG = 3'd0;
	localparam logic [COLOR_W-1:0] RESET_COLOR = {1'b0, DEFAULT_BG, 1'b0, DEFAULT_FG};

	typedef struct packed {
		logic [SW_W-1:0] eff_width;
		logic [SH_W-1:0] eff_height;
	} cfg_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic signed [COORD_W-1:0] x_pos;
		logic signed [COORD_W-1:0] y_pos;
		logic [SIZE_W-1:0] rect_width;
		logic [SIZE_W-1:0] rect_height;
		logic [CHAR_W-1:0] fill_char;
		logic [PAT_W-1:0] pattern_chars;
		logic [COLOR_W-1:0] cell_color;
	} item_t;

	typedef struct packed {
		logic clr_en;
		logic accept;
		logic setup_en;
		logic clip_en;
		logic walk_en;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic in_read;
		logic in_rect;
		logic empty;
		logic walk_last;
		logic out_free;
	} ctrl_sts_t;

endpackage

// File: rtl/text_cell_rect_draw_engine.sv
// channel  dir  handshake                 payload
// s_       in   s_tvalid / s_tready       s_tdata: command operands, s_tuser: kind
// m_       out  m_tvalid / m_tready       m_tdata: read cell, m_tuser: in_range
// apb      in   psel, penable / pready    screen_width at 0x0, screen_height at 0x4
//
// after reset a clearing pass writes every one of the 8192 store entries, one per cycle;
// no command transfer is taken during the clearing pass, register writes are taken at any time
// a cell write or an unused kind is finished in the cycle it is taken, a read also waits for any m_tready stall
// a rectangle passes through the setup and clip states, then walks each on-screen cell it covers
// through the single store write port; commands are taken one at a time, a waiting result does not stall
// commands that produce none
module text_cell_rect_draw_engine (
	input logic clk,
	input logic arst_n,

	input logic s_tvalid,
	output logic s_tready,
	// x_pos[11:0], y_pos[23:12], rect_width[35:24], rect_height[47:36],
	// fill_char[55:48], pattern_chars[79:56], cell_color[87:80]
	input logic [tcrd_pkg::S_TDATA_W-1:0] s_tdata,
	// kind[2:0]
	input logic [tcrd_pkg::KIND_W-1:0] s_tuser,

	output logic m_tvalid,
	input logic m_tready,
	// read_char[7:0], read_color[15:8]
	output logic [tcrd_pkg::M_TDATA_W-1:0] m_tdata,
	// in_range[0]
	output logic m_tuser,

	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [tcrd_pkg::APB_AW-1:0] paddr,
	input logic [tcrd_pkg::APB_DW-1:0] pwdata,
	output logic [tcrd_pkg::APB_DW-1:0] prdata,
	output logic pready
);

	tcrd_pkg::cfg_t cfg;
	tcrd_pkg::item_t item;
	tcrd_pkg::ctrl_cmd_t cmd;
	tcrd_pkg::ctrl_sts_t sts;
	logic [tcrd_pkg::CHAR_W-1:0] out_char;
	logic [tcrd_pkg::COLOR_W-1:0] out_color;

	assign pready = 1'b1;

	assign item.kind = s_tuser;
	assign item.x_pos = s_tdata[11:0];
	assign item.y_pos = s_tdata[23:12];
	assign item.rect_width = s_tdata[35:24];
	assign item.rect_height = s_tdata[47:36];
	assign item.fill_char = s_tdata[55:48];
	assign item.pattern_chars = s_tdata[79:56];
	assign item.cell_color = s_tdata[87:80];

	assign m_tdata = {out_color, out_char};

	tcrd_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.cfg(cfg)
	);

	tcrd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts(sts),
		.cmd(cmd)
	);

	tcrd_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.item(item),
		.cmd(cmd),
		.sts(sts),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_char(out_char),
		.out_color(out_color),
		.out_range(m_tuser)
	);

endmodule

// File: rtl/tcrd_regs.sv
module tcrd_regs (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [tcrd_pkg::APB_AW-1:0] paddr,
	input logic [tcrd_pkg::APB_DW-1:0] pwdata,
	output logic [tcrd_pkg::APB_DW-1:0] prdata,
	output tcrd_pkg::cfg_t cfg
);

	logic [tcrd_pkg::SW_W-1:0] width_q;
	logic [tcrd_pkg::SH_W-1:0] height_q;
	logic wr_en;
	logic reg_sel;

	assign wr_en = psel & penable & pwrite;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= tcrd_pkg::WIDTH_RESET;
			height_q <= tcrd_pkg::HEIGHT_RESET;
		end else if (wr_en) begin
			case (reg_sel)
				tcrd_pkg::REG_WIDTH: width_q <= pwdata[tcrd_pkg::SW_W-1:0];
				tcrd_pkg::REG_HEIGHT: height_q <= pwdata[tcrd_pkg::SH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			tcrd_pkg::REG_HEIGHT: prdata = tcrd_pkg::APB_DW'(height_q);
			default: prdata = tcrd_pkg::APB_DW'(width_q);
		endcase
	end

	// oversized settings fall back to the store size
	assign cfg.eff_width = (width_q > tcrd_pkg::SW_W'(tcrd_pkg::MAX_COLUMNS)) ?
		tcrd_pkg::SW_W'(tcrd_pkg::MAX_COLUMNS) : width_q;
	assign cfg.eff_height = (height_q > tcrd_pkg::SH_W'(tcrd_pkg::MAX_ROWS)) ?
		tcrd_pkg::SH_W'(tcrd_pkg::MAX_ROWS) : height_q;

endmodule

// File: rtl/tcrd_ctrl.sv
module tcrd_ctrl (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input tcrd_pkg::ctrl_sts_t sts,
	output tcrd_pkg::ctrl_cmd_t cmd
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_SETUP = 3'd2;
	localparam logic [2:0] ST_CLIP = 3'd3;
	localparam logic [2:0] ST_WALK = 3'd4;
	localparam logic [2:0] ST_READ = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (sts.clr_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					if (sts.in_read) begin
						state_nxt = ST_READ;
					end else if (sts.in_rect) begin
						state_nxt = ST_SETUP;
					end
				end
			end
			ST_SETUP: begin
				cmd.setup_en = 1'b1;
				state_nxt = ST_CLIP;
			end
			ST_CLIP: begin
				cmd.clip_en = 1'b1;
				state_nxt = sts.empty ? ST_IDLE : ST_WALK;
			end
			ST_WALK: begin
				cmd.walk_en = 1'b1;
				if (sts.walk_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_READ: begin
				// wait for the output register to free up
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

endmodule

// File: rtl/tcrd_dp.sv
module tcrd_dp (
	input logic clk,
	input logic arst_n,
	input tcrd_pkg::cfg_t cfg,
	input tcrd_pkg::item_t item,
	input tcrd_pkg::ctrl_cmd_t cmd,
	output tcrd_pkg::ctrl_sts_t sts,
	output logic out_valid,
	input logic out_ready,
	output logic [tcrd_pkg::CHAR_W-1:0] out_char,
	output logic [tcrd_pkg::COLOR_W-1:0] out_color,
	output logic out_range
);

	localparam int XW = tcrd_pkg::EXT_W;
	localparam int CW = tcrd_pkg::CHAR_W;

	// cell store and its ports
	logic [tcrd_pkg::CELL_W-1:0] mem_q [tcrd_pkg::MEM_DEPTH];
	logic [tcrd_pkg::CELL_W-1:0] rdata_q;
	logic mem_we;
	logic [tcrd_pkg::ADDR_W-1:0] mem_waddr;
	logic [tcrd_pkg::CELL_W-1:0] mem_wdata;
	logic mem_re;

	logic [tcrd_pkg::ADDR_W-1:0] clr_cnt_q;

	// incoming item decode
	logic signed [XW-1:0] in_x;
	logic signed [XW-1:0] in_y;
	logic signed [XW-1:0] lim_w;
	logic signed [XW-1:0] lim_h;
	logic in_on;
	logic [tcrd_pkg::ADDR_W-1:0] in_addr;

	// command registers
	logic [tcrd_pkg::KIND_W-1:0] kind_q;
	logic signed [XW-1:0] x_q;
	logic signed [XW-1:0] y_q;
	logic [tcrd_pkg::SIZE_W-1:0] w_q;
	logic [tcrd_pkg::SIZE_W-1:0] h_q;
	logic [CW-1:0] ch_q;
	logic [tcrd_pkg::PAT_W-1:0] pat_q;
	logic [tcrd_pkg::COLOR_W-1:0] col_q;
	logic rd_ok_q;

	// clip bounds
	logic signed [XW-1:0] x_sum;
	logic signed [XW-1:0] y_sum;
	logic signed [XW-1:0] x0_q;
	logic signed [XW-1:0] y0_q;
	logic signed [XW-1:0] x_end_q;
	logic signed [XW-1:0] y_end_q;
	logic signed [XW-1:0] x_last_q;
	logic signed [XW-1:0] y_last_q;

	// walk
	logic [tcrd_pkg::COL_W-1:0] ci_q;
	logic [tcrd_pkg::ROW_W-1:0] ri_q;
	logic signed [XW-1:0] ci_ext;
	logic signed [XW-1:0] ri_ext;
	logic col_last;
	logic row_last;
	logic vedge;
	logic hedge;
	logic walk_we;
	logic [CW-1:0] walk_char;

	assign in_x = XW'($signed(item.x_pos));
	assign in_y = XW'($signed(item.y_pos));
	assign lim_w = $signed(XW'(cfg.eff_width));
	assign lim_h = $signed(XW'(cfg.eff_height));
	assign in_on = (in_x >= 0) && (in_x < lim_w) && (in_y >= 0) && (in_y < lim_h);
	assign in_addr = {item.y_pos[tcrd_pkg::ROW_W-1:0], item.x_pos[tcrd_pkg::COL_W-1:0]};

	assign sts.clr_last = &clr_cnt_q;
	assign sts.in_read = (item.kind == tcrd_pkg::KIND_READ);
	assign sts.in_rect = (item.kind == tcrd_pkg::KIND_FILL) ||
		(item.kind == tcrd_pkg::KIND_OUTLINE) || (item.kind == tcrd_pkg::KIND_PATTERN);
	assign sts.empty = (x0_q >= x_end_q) || (y0_q >= y_end_q);
	assign sts.walk_last = col_last && row_last;
	assign sts.out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_en) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q <= item.kind;
			x_q <= in_x;
			y_q <= in_y;
			w_q <= item.rect_width;
			h_q <= item.rect_height;
			ch_q <= item.fill_char;
			pat_q <= item.pattern_chars;
			col_q <= item.cell_color;
			rd_ok_q <= in_on;
		end
	end

	// setup: near edges clamped to zero, far edges clipped to the screen
	assign x_sum = x_q + $signed(XW'(w_q));
	assign y_sum = y_q + $signed(XW'(h_q));

	always_ff @(posedge clk) begin
		if (cmd.setup_en) begin
			x0_q <= (x_q < 0) ? '0 : x_q;
			y0_q <= (y_q < 0) ? '0 : y_q;
			x_end_q <= (x_sum > lim_w) ? lim_w : x_sum;
			y_end_q <= (y_sum > lim_h) ? lim_h : y_sum;
			x_last_q <= x_sum - XW'(1);
			y_last_q <= y_sum - XW'(1);
		end
	end

	assign ci_ext = $signed(XW'(ci_q));
	assign ri_ext = $signed(XW'(ri_q));
	assign col_last = (ci_ext + XW'(1)) >= x_end_q;
	assign row_last = (ri_ext + XW'(1)) >= y_end_q;
	assign vedge = (ci_ext == x_q) || (ci_ext == x_last_q);
	assign hedge = (ri_ext == y_q) || (ri_ext == y_last_q);

	// column runs fastest, row steps at the right clip edge
	always_ff @(posedge clk) begin
		if (cmd.clip_en) begin
			ci_q <= x0_q[tcrd_pkg::COL_W-1:0];
			ri_q <= y0_q[tcrd_pkg::ROW_W-1:0];
		end else if (cmd.walk_en) begin
			if (col_last) begin
				ci_q <= x0_q[tcrd_pkg::COL_W-1:0];
				ri_q <= ri_q + 1'b1;
			end else begin
				ci_q <= ci_q + 1'b1;
			end
		end
	end

	always_comb begin
		walk_we = 1'b0;
		walk_char = ch_q;
		case (kind_q)
			tcrd_pkg::KIND_FILL: walk_we = 1'b1;
			tcrd_pkg::KIND_OUTLINE: walk_we = vedge | hedge;
			tcrd_pkg::KIND_PATTERN: begin
				walk_we = vedge | hedge;
				if (vedge && hedge) begin
					walk_char = pat_q[0 +: CW];
				end else if (vedge) begin
					walk_char = pat_q[2*CW +: CW];
				end else begin
					walk_char = pat_q[CW +: CW];
				end
			end
			default: walk_we = 1'b0;
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = clr_cnt_q;
		mem_wdata = {tcrd_pkg::CHAR_SPACE, tcrd_pkg::RESET_COLOR};
		if (cmd.clr_en) begin
			mem_we = 1'b1;
		end else if (cmd.accept && item.kind == tcrd_pkg::KIND_WRITE && in_on) begin
			mem_we = 1'b1;
			mem_waddr = in_addr;
			mem_wdata = {item.fill_char, item.cell_color};
		end else if (cmd.walk_en && walk_we) begin
			mem_we = 1'b1;
			mem_waddr = {ri_q, ci_q};
			mem_wdata = {walk_char, col_q};
		end
	end

	assign mem_re = cmd.accept && sts.in_read;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem_q[in_addr];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_char <= rd_ok_q ? rdata_q[tcrd_pkg::CELL_W-1:tcrd_pkg::COLOR_W] : '0;
			out_color <= rd_ok_q ? rdata_q[tcrd_pkg::COLOR_W-1:0] : '0;
			out_range <= rd_ok_q;
		end
	end

endmodule

// File: rtl/tcrd_checker.sv
module tcrd_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic [tcrd_pkg::KIND_W-1:0] s_tuser,
	input logic m_tvalid,
	input logic m_tready,
	input logic [tcrd_pkg::M_TDATA_W-1:0] m_tdata,
	input logic m_tuser
);

	logic s_xfer;
	logic rect_xfer;

	assign s_xfer = s_tvalid && s_tready;
	assign rect_xfer = s_xfer && (s_tuser == tcrd_pkg::KIND_FILL ||
		s_tuser == tcrd_pkg::KIND_OUTLINE || s_tuser == tcrd_pkg::KIND_PATTERN);

	// a read holds off the next command while its result is fetched
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer && s_tuser == tcrd_pkg::KIND_READ |=> !s_tready)
		else $error("command taken right after a read");

	// rectangles always pass through the setup state
	a_rect_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rect_xfer |=> !s_tready)
		else $error("command taken right after a rectangle");

	// only reads produce a result
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer && s_tuser != tcrd_pkg::KIND_READ && !m_tvalid |=> !m_tvalid)
		else $error("result without a read");

	// off-screen reads carry zero data
	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("off-screen read with nonzero data");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind text_cell_rect_draw_engine tcrd_checker u_tcrd_checker (.*);

// File: test/tb_text_cell_rect_draw_engine.sv
module tb_text_cell_rect_draw_engine;
	timeunit 1ns;
	timeprecision 1ps;

	import tcrd_pkg::*;

	localparam int LIMIT_CYCLES = 3_000_000;
	// longest rectangle walk plus setup
	localparam int DRAIN_CYCLES = MEM_DEPTH + 64;
	localparam int LONG_HOLD = 3000;
	localparam int PHASE_ITEMS = 172;
	localparam int PHASES = 7;
	localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
	localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
	localparam logic [PAT_W-1:0] BOX_PATTERN = 24'h7C2D2B;

	typedef struct {
		logic [CHAR_W-1:0] ch;
		logic [COLOR_W-1:0] color;
		logic in_range;
	} cell_read_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic s_tvalid = 1'b0;
	logic s_tready;
	// x_pos, y_pos, rect_width, rect_height, fill_char, pattern_chars, cell_color
	logic [S_TDATA_W-1:0] s_tdata = '0;
	// kind
	logic [KIND_W-1:0] s_tuser = '0;

	logic m_tvalid;
	logic m_tready = 1'b0;
	// read_char, read_color
	logic [M_TDATA_W-1:0] m_tdata;
	// in_range
	logic m_tuser;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;

	logic [CELL_W-1:0] screen_mem [MEM_DEPTH];
	logic [SW_W-1:0] cols_reg = WIDTH_RESET;
	logic [SH_W-1:0] rows_reg = HEIGHT_RESET;

	item_t pending_cmds[$];
	cell_read_t read_expect[$];
	item_t cur_cmd;
	logic [COORD_W-1:0] last_x = '0;
	logic [COORD_W-1:0] last_y = '0;

	int queued_total = 0;
	int taken_total = 0;
	int errors = 0;
	int cycle_cnt = 0;
	int tx_gap = 0;
	int rx_gap = 0;
	int rx_hold = 0;
	int hold_requests = 0;
	int hold_served = 0;
	bit tx_offer = 1'b0;
	bit tx_pause = 1'b0;
	bit tx_gaps_on = 1'b0;
	bit rx_gaps_on = 1'b0;

	text_cell_rect_draw_engine u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic int eff_cols();
		return (cols_reg > MAX_COLUMNS) ? MAX_COLUMNS : int'(cols_reg);
	endfunction

	function automatic int eff_rows();
		return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
	endfunction

	function automatic bit on_screen(int x, int y);
		return x >= 0 && x < eff_cols() && y >= 0 && y < eff_rows();
	endfunction

	function automatic void put_cell(int x, int y, logic [CHAR_W-1:0] ch,
			logic [COLOR_W-1:0] col);
		if (on_screen(x, y))
			screen_mem[y * MAX_COLUMNS + x] = {ch, col};
	endfunction

	// updates the screen copy and queues the readout of a read command
	function automatic void apply_command(item_t c);
		int x, y, w, h, x0, x1, y0, y1;
		bit vedge, hedge;
		cell_read_t r;
		x = int'($signed(c.x_pos));
		y = int'($signed(c.y_pos));
		w = int'(c.rect_width);
		h = int'(c.rect_height);
		case (c.kind)
			KIND_WRITE: put_cell(x, y, c.fill_char, c.cell_color);
			KIND_READ: begin
				if (on_screen(x, y)) begin
					r.ch = screen_mem[y * MAX_COLUMNS + x][CELL_W-1:COLOR_W];
					r.color = screen_mem[y * MAX_COLUMNS + x][COLOR_W-1:0];
					r.in_range = 1'b1;
				end else begin
					r.ch = '0;
					r.color = '0;
					r.in_range = 1'b0;
				end
				read_expect.push_back(r);
			end
			KIND_FILL, KIND_OUTLINE, KIND_PATTERN: begin
				x0 = (x < 0) ? 0 : x;
				y0 = (y < 0) ? 0 : y;
				x1 = (x + w > eff_cols()) ? eff_cols() : x + w;
				y1 = (y + h > eff_rows()) ? eff_rows() : y + h;
				for (int i = x0; i < x1; i++) begin
					vedge = (i == x) || (i == x + w - 1);
					for (int j = y0; j < y1; j++) begin
						hedge = (j == y) || (j == y + h - 1);
						if (c.kind == KIND_FILL)
							put_cell(i, j, c.fill_char, c.cell_color);
						else if (c.kind == KIND_OUTLINE) begin
							if (vedge || hedge)
								put_cell(i, j, c.fill_char, c.cell_color);
						end else if (vedge && hedge)
							put_cell(i, j, c.pattern_chars[7:0], c.cell_color);
						else if (vedge)
							put_cell(i, j, c.pattern_chars[23:16], c.cell_color);
						else if (hedge)
							put_cell(i, j, c.pattern_chars[15:8], c.cell_color);
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic item_t make_cmd(logic [KIND_W-1:0] k, int x, int y, int w, int h,
			logic [CHAR_W-1:0] ch, logic [PAT_W-1:0] pat, logic [COLOR_W-1:0] col);
		item_t c;
		c.kind = k;
		c.x_pos = COORD_W'(x);
		c.y_pos = COORD_W'(y);
		c.rect_width = SIZE_W'(w);
		c.rect_height = SIZE_W'(h);
		c.fill_char = ch;
		c.pattern_chars = pat;
		c.cell_color = col;
		return c;
	endfunction

	function automatic item_t random_command();
		item_t c;
		int r;
		int ew, eh;
		ew = eff_cols();
		eh = eff_rows();
		r = $urandom_range(0, 99);
		if (r < 25)
			c.kind = KIND_WRITE;
		else if (r < 35)
			c.kind = KIND_FILL;
		else if (r < 45)
			c.kind = KIND_OUTLINE;
		else if (r < 55)
			c.kind = KIND_PATTERN;
		else if (r < 95)
			c.kind = KIND_READ;
		else
			c.kind = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
		if ($urandom_range(0, 4) == 0) begin
			c.x_pos = COORD_W'($urandom);
			c.y_pos = COORD_W'($urandom);
		end else begin
			c.x_pos = COORD_W'($urandom_range(0, ew + 3) - 2);
			c.y_pos = COORD_W'($urandom_range(0, eh + 3) - 2);
		end
		// reads often land where something was just drawn
		if (c.kind == KIND_READ && $urandom_range(0, 2) == 0) begin
			c.x_pos = last_x;
			c.y_pos = last_y;
		end else if (c.kind != KIND_READ) begin
			last_x = c.x_pos;
			last_y = c.y_pos;
		end
		r = $urandom_range(0, 99);
		if (r < 85) begin
			c.rect_width = SIZE_W'($urandom_range(0, 9));
			c.rect_height = SIZE_W'($urandom_range(0, 9));
		end else if (r < 95) begin
			c.rect_width = SIZE_W'($urandom_range(0, 40));
			c.rect_height = SIZE_W'($urandom_range(0, 40));
		end else begin
			c.rect_width = SIZE_W'($urandom);
			c.rect_height = SIZE_W'($urandom);
		end
		c.fill_char = CHAR_W'($urandom);
		c.pattern_chars = PAT_W'($urandom);
		c.cell_color = COLOR_W'($urandom);
		return c;
	endfunction

	function automatic int gap_len();
		return ($urandom_range(0, 4) != 0) ? $urandom_range(1, 3) : $urandom_range(8, 40);
	endfunction

	function automatic void push_cmd(item_t c);
		pending_cmds.push_back(c);
		queued_total++;
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		$display("mismatch on %s: got %0h, expected %0h (cycle %0d)", what, got, want,
			cycle_cnt);
		errors++;
	endtask

	task automatic apb_write(logic reg_idx, logic [APB_DW-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {reg_idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_idx == REG_WIDTH)
			cols_reg = value[SW_W-1:0];
		else
			rows_reg = value[SH_W-1:0];
	endtask

	// every command taken and every readout back, then room for a rectangle walk
	task automatic wait_idle();
		while (taken_total != queued_total || read_expect.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// command sender
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			apply_command(cur_cmd);
			taken_total++;
		end
		if (!s_tvalid || s_tready) begin
			if (tx_gap > 0) begin
				tx_gap--;
				tx_offer = 1'b0;
			end else if (pending_cmds.size() > 0 && !tx_pause && arst_n) begin
				cur_cmd = pending_cmds.pop_front();
				s_tdata <= {cur_cmd.cell_color, cur_cmd.pattern_chars, cur_cmd.fill_char,
					cur_cmd.rect_height, cur_cmd.rect_width, cur_cmd.y_pos, cur_cmd.x_pos};
				s_tuser <= cur_cmd.kind;
				tx_offer = 1'b1;
				tx_gap = (tx_gaps_on && $urandom_range(0, 3) == 0) ? gap_len() : 0;
			end else begin
				tx_offer = 1'b0;
			end
			s_tvalid <= tx_offer;
		end
	end

	// readout receiver and checker
	always @(posedge clk) begin : rx_side
		cell_read_t want;
		if (m_tvalid && m_tready) begin
			if (read_expect.size() == 0) begin
				report_mismatch("unexpected readout", m_tdata, '0);
			end else begin
				want = read_expect.pop_front();
				if (m_tdata[7:0] !== want.ch)
					report_mismatch("read_char", 16'(m_tdata[7:0]), 16'(want.ch));
				if (m_tdata[15:8] !== want.color)
					report_mismatch("read_color", 16'(m_tdata[15:8]), 16'(want.color));
				if (m_tuser !== want.in_range)
					report_mismatch("in_range", 16'(m_tuser), 16'(want.in_range));
			end
		end
		if (hold_served < hold_requests) begin
			hold_served++;
			rx_hold = LONG_HOLD;
		end
		if (rx_hold > 0) begin
			rx_hold--;
			m_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (rx_gaps_on && $urandom_range(0, 3) == 0)
				rx_gap = gap_len();
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("text_cell_rect_draw_engine test failed");
			$finish;
		end
	end

	initial begin : stimulus
		logic [SW_W-1:0] phase_cols [PHASES] = '{8'd128, 8'd255, 8'd1, 8'd0, 8'd37, 8'd200,
			8'd9};
		logic [SH_W-1:0] phase_rows [PHASES] = '{7'd64, 7'd127, 7'd1, 7'd11, 7'd0, 7'd100,
			7'd3};
		logic [APB_DW-1:0] reg_val;
		for (int i = 0; i < MEM_DEPTH; i++)
			screen_mem[i] = {CHAR_SPACE, RESET_COLOR};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed part on the reset screen size
		push_cmd(make_cmd(KIND_READ, 0, 0, 0, 0, 8'h00, '0, 8'h00));
		push_cmd(make_cmd(KIND_WRITE, 0, 0, 0, 0, 8'hFF, '1, 8'hFF));
		push_cmd(make_cmd(KIND_READ, 0, 0, 0, 0, 8'h00, '0, 8'h00));
		push_cmd(make_cmd(KIND_WRITE, 79, 24, 0, 0, 8'h00, '0, 8'h00));
		push_cmd(make_cmd(KIND_READ, 79, 24, 0, 0, 8'h00, '0, 8'h00));
		// write just past the right edge is dropped
		push_cmd(make_cmd(KIND_WRITE, 80, 0, 0, 0, 8'h55, '0, 8'h55));
		push_cmd(make_cmd(KIND_READ, 80, 0, 0, 0, 8'h00, '0, 8'h00));
		push_cmd(make_cmd(KIND_READ, -2048, -2048, 0, 0, 8'hFF, '1, 8'hFF));
		push_cmd(make_cmd(KIND_READ, 2047, 2047, 4095, 4095, 8'hFF, '1, 8'hFF));
		// whole-screen fill from far off the top left corner
		push_cmd(make_cmd(KIND_FILL, -2048, -2048, 4095, 4095, 8'h41, '1, 8'hAA));
		push_cmd(make_cmd(KIND_READ, 40, 12, 0, 0, 8'h00, '0, 8'h00));
		push_cmd(make_cmd(KIND_OUTLINE, 2, 2, 5, 4, 8'h42, '0, 8'h0F));
		push_cmd(make_cmd(KIND_READ, 6, 5, 0, 0, 8'h00, '0, 8'h00));
		push_cmd(make_cmd(KIND_READ, 4, 3, 0, 0, 8'h00, '0, 8'h00));
		push_cmd(make_cmd(KIND_PATTERN, 10, 10, 4, 3, 8'h00, BOX_PATTERN, 8'h70));
		push_cmd(make_cmd(KIND_READ, 10, 10, 0, 0, 8'h00, '0, 8'h00));
		push_cmd(make_cmd(KIND_READ, 11, 10, 0, 0, 8'h00, '0, 8'h00));
		push_cmd(make_cmd(KIND_READ, 13, 11, 0, 0, 8'h00, '0, 8'h00));
		push_cmd(make_cmd(KIND_READ, 11, 11, 0, 0, 8'h00, '0, 8'h00));
		// pattern box whose top and left edges are clipped away
		push_cmd(make_cmd(KIND_PATTERN, -1, -1, 3, 3, 8'h00, 24'h5A5B5C, 8'h80));
		push_cmd(make_cmd(KIND_READ, 1, 1, 0, 0, 8'h00, '0, 8'h00));
		push_cmd(make_cmd(KIND_READ, 0, 1, 0, 0, 8'h00, '0, 8'h00));
		push_cmd(make_cmd(KIND_FILL, 5, 5, 0, 3, 8'h43, '0, 8'h11));
		push_cmd(make_cmd(KIND_SPARE_LO, 5, 5, 1, 1, 8'h44, '0, 8'h22));
		push_cmd(make_cmd(KIND_SPARE_HI, 5, 5, 1, 1, 8'h45, '0, 8'h33));
		push_cmd(make_cmd(KIND_READ, 5, 5, 0, 0, 8'h00, '0, 8'h00));
		wait_idle();

		for (int p = 0; p < PHASES; p++) begin
			reg_val = $urandom;
			reg_val[SW_W-1:0] = phase_cols[p];
			apb_write(REG_WIDTH, reg_val);
			reg_val = $urandom;
			reg_val[SH_W-1:0] = phase_rows[p];
			apb_write(REG_HEIGHT, reg_val);
			{tx_gaps_on, rx_gaps_on} = 2'(p + 1);
			for (int n = 0; n < PHASE_ITEMS; n++)
				push_cmd(random_command());
			if (p == 0) begin
				// readouts back up behind a long receiver hold and stall the input
				hold_requests++;
				while (pending_cmds.size() > PHASE_ITEMS / 2)
					@(posedge clk);
				tx_pause = 1'b1;
				@(posedge clk);
				while (tx_offer || read_expect.size() != 0)
					@(posedge clk);
				tx_pause = 1'b0;
			end
			wait_idle();
		end

		if (errors == 0)
			$display("text_cell_rect_draw_engine test passed");
		else
			$display("text_cell_rect_draw_engine test failed");
		$finish;
	end

endmodule
